FILE: hdl/duration_text_to_ms_parser_defines.svh
// Assertion macros shared by the duration parser RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef DURATION_TEXT_TO_MS_PARSER_DEFINES_SVH
`define DURATION_TEXT_TO_MS_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define DTM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dtm assertion failed");
`define DTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtm assertion failed");
`define DTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtm assertion failed");
`else
`define DTM_ASSERT(lbl, clk, rst_n, prop)
`define DTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/dtm_pkg.sv
// Types, codes and unit word table for the duration text parser.
// No dependencies; used by dtm_scan and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dtm_pkg;

    localparam int unsigned MAX_MS  = 86400 * 1000;
    localparam int unsigned MULT_MS = 1;
    localparam int unsigned MULT_S  = 1000;
    localparam int unsigned MULT_M  = 60 * 1000;
    localparam int unsigned MULT_H  = 3600 * 1000;

    localparam int N_WORDS   = 20;
    localparam int UNIT_MAX  = 12;
    localparam int MS_W      = 27;
    localparam int MULT_W    = 22;

    // scan phases
    localparam logic [1:0] PH_LEAD   = 2'd0;
    localparam logic [1:0] PH_OPEN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_UNIT   = 2'd3;

    // result codes
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_EMPTY    = 3'd1;
    localparam logic [2:0] ERR_NEGATIVE = 3'd2;
    localparam logic [2:0] ERR_NO_DIGIT = 3'd3;
    localparam logic [2:0] ERR_TOO_BIG  = 3'd4;
    localparam logic [2:0] ERR_UNIT     = 3'd5;
    localparam logic [2:0] ERR_OVER_24H = 3'd6;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // words are right-justified: first character in the highest used byte
    localparam logic [8*UNIT_MAX-1:0] UNIT_WORD [N_WORDS] = '{
        "ms", "msec", "millis", "millisecond", "milliseconds",
        "s", "sec", "secs", "second", "seconds",
        "m", "min", "mins", "minute", "minutes",
        "h", "hr", "hrs", "hour", "hours"
    };

    localparam logic [3:0] UNIT_LEN [N_WORDS] = '{
        4'd2, 4'd4, 4'd6, 4'd11, 4'd12,
        4'd1, 4'd3, 4'd4, 4'd6, 4'd7,
        4'd1, 4'd3, 4'd4, 4'd6, 4'd7,
        4'd1, 4'd2, 4'd3, 4'd4, 4'd5
    };

    localparam logic [MULT_W-1:0] UNIT_MULT [N_WORDS] = '{
        MULT_W'(MULT_MS), MULT_W'(MULT_MS), MULT_W'(MULT_MS), MULT_W'(MULT_MS),
        MULT_W'(MULT_MS),
        MULT_W'(MULT_S), MULT_W'(MULT_S), MULT_W'(MULT_S), MULT_W'(MULT_S),
        MULT_W'(MULT_S),
        MULT_W'(MULT_M), MULT_W'(MULT_M), MULT_W'(MULT_M), MULT_W'(MULT_M),
        MULT_W'(MULT_M),
        MULT_W'(MULT_H), MULT_W'(MULT_H), MULT_W'(MULT_H), MULT_W'(MULT_H),
        MULT_W'(MULT_H)
    };

    // largest count that stays within 24 hours for each unit
    localparam logic [MS_W-1:0] LIM_MS = MS_W'(MAX_MS / MULT_MS);
    localparam logic [MS_W-1:0] LIM_S  = MS_W'(MAX_MS / MULT_S);
    localparam logic [MS_W-1:0] LIM_M  = MS_W'(MAX_MS / MULT_M);
    localparam logic [MS_W-1:0] LIM_H  = MS_W'(MAX_MS / MULT_H);

    localparam logic [MS_W-1:0] UNIT_LIMIT [N_WORDS] = '{
        LIM_MS, LIM_MS, LIM_MS, LIM_MS, LIM_MS,
        LIM_S, LIM_S, LIM_S, LIM_S, LIM_S,
        LIM_M, LIM_M, LIM_M, LIM_M, LIM_M,
        LIM_H, LIM_H, LIM_H, LIM_H, LIM_H
    };

    typedef struct packed {
        logic [1:0]         phase;
        logic               quote_opened;
        logic               held_quote;
        logic               held_space;
        logic [MS_W-1:0]    acc;
        logic [N_WORDS-1:0] cand;       // unit words still matching the suffix
        logic [3:0]         ulen;
        logic               uinv;
        logic [2:0]         err;
    } t_scan;

    localparam t_scan SCAN_RESET = '{
        phase: PH_LEAD, quote_opened: 1'b0, held_quote: 1'b0, held_space: 1'b0,
        acc: '0, cand: '1, ulen: 4'd0, uinv: 1'b0, err: ERR_OK
    };

    // character at position pos of unit word w, zero past its end
    function automatic logic [7:0] unit_char(input int w, input logic [3:0] pos);
        int sh;
        sh = int'(UNIT_LEN[w]) - 1 - int'(pos);
        if (sh < 0) begin
            return 8'h00;
        end
        return UNIT_WORD[w][sh*8 +: 8];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/duration_text_to_ms_parser.sv
// Duration text parser: one text byte per request, one byte per cycle sustained.
// A byte is held in the input register, then the combinational scan stage folds
// it into the parser state register; on the byte marked last the result lands in
// the output register as that byte leaves the input register. Only a final
// byte waits behind a result that the receiver has not taken; the input stalls
// while such a byte is held. The scan state update (digit multiply-add plus suffix
// match) is the one loop that sets the byte rate.
// Depends on dtm_pkg, dtm_scan and the defines header.
`timescale 1ns / 1ps
`default_nettype none

`include "duration_text_to_ms_parser_defines.svh"

module duration_text_to_ms_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_last_char,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [26:0]      o_duration_ms,
    output logic [2:0]       o_error_code
);

    logic                    r_in_valid;
    logic [7:0]              r_in_char;
    logic                    r_in_last;
    dtm_pkg::t_scan          r_state;
    dtm_pkg::t_scan          n_state;
    logic                    r_out_valid;
    logic [26:0]             r_out_ms;
    logic [2:0]              r_out_err;
    logic [26:0]             n_ms;
    logic [2:0]              n_err;
    logic                    advance;
    logic                    in_acc;

    dtm_scan u_scan (
        .i_state       (r_state),
        .i_char_code   (r_in_char),
        .o_state       (n_state),
        .o_duration_ms (n_ms),
        .o_error_code  (n_err)
    );

    // only a final byte needs the output register free
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtm_pkg::SCAN_RESET;
        end else if (advance) begin
            r_state <= r_in_last ? dtm_pkg::SCAN_RESET : n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_ms  <= n_ms;
            r_out_err <= n_err;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_duration_ms = r_out_ms;
    assign o_error_code  = r_out_err;

    `DTM_ASSERT_IMP(a_err_no_ms, i_clk, i_rst_n, r_out_valid && r_out_err != dtm_pkg::ERR_OK, r_out_ms == 27'd0)
    `DTM_ASSERT_IMP(a_ms_range, i_clk, i_rst_n, r_out_valid, r_out_ms <= 27'(dtm_pkg::MAX_MS))
    `DTM_ASSERT(a_acc_range, i_clk, i_rst_n, r_state.acc <= 27'(dtm_pkg::MAX_MS))
    `DTM_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, advance && r_in_last, r_state == dtm_pkg::SCAN_RESET && r_out_valid)

endmodule

`default_nettype wire

FILE: hdl/dtm_scan.sv
// Next-state and result logic for one text byte of the duration parser.
// Purely combinational; uses dtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtm_scan (
    input  wire dtm_pkg::t_scan          i_state,
    input  wire logic [7:0]              i_char_code,
    output dtm_pkg::t_scan               o_state,
    output logic [dtm_pkg::MS_W-1:0]     o_duration_ms,
    output logic [2:0]                   o_error_code
);

    function automatic logic is_blank(input logic [7:0] c);
        return (c == dtm_pkg::CH_SPACE) || (c >= dtm_pkg::CH_TAB && c <= dtm_pkg::CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= dtm_pkg::CH_0) && (c <= dtm_pkg::CH_9);
    endfunction

    // one content byte into the scanner
    function automatic dtm_pkg::t_scan take(input dtm_pkg::t_scan s, input logic [7:0] c);
        dtm_pkg::t_scan r;
        logic [29:0]    v;
        logic [7:0]     lc;
        r  = s;
        v  = 30'(s.acc) * 30'd10 + 30'(c - dtm_pkg::CH_0);
        lc = (c >= dtm_pkg::CH_UA && c <= dtm_pkg::CH_UZ) ? c + 8'd32 : c;
        if (s.err == dtm_pkg::ERR_OK) begin
            if (s.phase == dtm_pkg::PH_OPEN) begin
                if (c == dtm_pkg::CH_MINUS) begin
                    r.err = dtm_pkg::ERR_NEGATIVE;
                end else if (is_digit(c)) begin
                    r.acc   = dtm_pkg::MS_W'(c - dtm_pkg::CH_0);
                    r.phase = dtm_pkg::PH_DIGITS;
                end else begin
                    r.err = dtm_pkg::ERR_NO_DIGIT;
                end
            end else if (s.phase == dtm_pkg::PH_DIGITS && is_digit(c)) begin
                if (v > 30'(dtm_pkg::MAX_MS)) begin
                    r.err = dtm_pkg::ERR_TOO_BIG;
                end else begin
                    r.acc = v[dtm_pkg::MS_W-1:0];
                end
            end else begin
                r.phase = dtm_pkg::PH_UNIT;
                if (s.ulen >= 4'(dtm_pkg::UNIT_MAX)) begin
                    r.uinv = 1'b1;
                end else begin
                    // suffix is matched as it arrives instead of buffered
                    for (int w = 0; w < dtm_pkg::N_WORDS; w++) begin
                        r.cand[w] = s.cand[w] && (dtm_pkg::UNIT_LEN[w] > s.ulen) &&
                                    (dtm_pkg::unit_char(w, s.ulen) == lc);
                    end
                    r.ulen = s.ulen + 4'd1;
                end
            end
        end
        return r;
    endfunction

    dtm_pkg::t_scan          n_s;
    logic [dtm_pkg::N_WORDS-1:0] hit;
    logic [dtm_pkg::MULT_W-1:0]  mult;
    logic [dtm_pkg::MS_W-1:0]    limit;
    logic [48:0]                 prod;

    always_comb begin
        n_s = i_state;
        if (i_state.phase == dtm_pkg::PH_LEAD) begin
            if (!is_blank(i_char_code)) begin
                n_s.phase = dtm_pkg::PH_OPEN;
                if (i_char_code == dtm_pkg::CH_QUOTE) begin
                    n_s.quote_opened = 1'b1;
                end else begin
                    n_s = take(n_s, i_char_code);
                end
            end
        end else if (is_blank(i_char_code)) begin
            n_s.held_space = 1'b1;
        end else begin
            if (n_s.held_quote) begin
                n_s = take(n_s, dtm_pkg::CH_QUOTE);
                n_s.held_quote = 1'b0;
            end
            if (n_s.held_space) begin
                n_s = take(n_s, dtm_pkg::CH_SPACE);
                n_s.held_space = 1'b0;
            end
            if (i_char_code == dtm_pkg::CH_QUOTE && n_s.quote_opened) begin
                n_s.held_quote = 1'b1;
            end else begin
                n_s = take(n_s, i_char_code);
            end
        end
    end

    assign o_state = n_s;

    // result as if this byte were the last one
    always_comb begin
        mult  = dtm_pkg::MULT_W'(dtm_pkg::MULT_S);
        limit = dtm_pkg::LIM_S;
        for (int w = 0; w < dtm_pkg::N_WORDS; w++) begin
            hit[w] = n_s.cand[w] && (dtm_pkg::UNIT_LEN[w] == n_s.ulen) && !n_s.uinv;
        end
        if (n_s.phase == dtm_pkg::PH_UNIT) begin
            mult  = '0;
            limit = '0;
            for (int w = 0; w < dtm_pkg::N_WORDS; w++) begin
                mult  = mult  | (hit[w] ? dtm_pkg::UNIT_MULT[w]  : '0);
                limit = limit | (hit[w] ? dtm_pkg::UNIT_LIMIT[w] : '0);
            end
        end
        prod = 49'(n_s.acc) * 49'(mult);

        o_duration_ms = '0;
        if (n_s.phase == dtm_pkg::PH_LEAD) begin
            o_error_code = dtm_pkg::ERR_EMPTY;
        end else if (n_s.quote_opened && !n_s.held_quote) begin
            o_error_code = dtm_pkg::ERR_NO_DIGIT;
        end else if (n_s.err != dtm_pkg::ERR_OK) begin
            o_error_code = n_s.err;
        end else if (n_s.phase == dtm_pkg::PH_OPEN) begin
            o_error_code = dtm_pkg::ERR_EMPTY;
        end else if (n_s.phase == dtm_pkg::PH_UNIT && hit == '0) begin
            o_error_code = dtm_pkg::ERR_UNIT;
        end else if (n_s.acc > limit) begin
            o_error_code = dtm_pkg::ERR_OVER_24H;
        end else begin
            o_error_code  = dtm_pkg::ERR_OK;
            o_duration_ms = prod[dtm_pkg::MS_W-1:0];
        end
    end

endmodule

`default_nettype wire
